/* design/iws_pkg.sv */
// Shared types and character constants for the identifier word splitter.
package iws_pkg;

  localparam int CHAR_W = 8;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t UNDERSCORE_C = 8'h5F;
  localparam char_t SPACE_C      = 8'h20;
  localparam char_t LOWER_A_C    = 8'h61;
  localparam char_t LOWER_Z_C    = 8'h7A;
  localparam char_t UPPER_A_C    = 8'h41;
  localparam char_t UPPER_Z_C    = 8'h5A;

  // Bytes emitted for one token byte, plus the emit flags that follow it.
  typedef struct packed {
    logic [1:0] cnt;
    char_t      b0;
    char_t      b1;
    logic       started;
    logic       last_sp;
  } emit_t;

  function automatic logic is_lower(char_t c);
    return (c >= LOWER_A_C) && (c <= LOWER_Z_C);
  endfunction

  function automatic logic is_upper(char_t c);
    return (c >= UPPER_A_C) && (c <= UPPER_Z_C);
  endfunction

endpackage

/* design/iws_if.sv */
// Valid/ready channel interfaces for the splitter's byte input and word output.
interface iws_in_if;
  import iws_pkg::*;
  logic  valid;
  logic  ready;
  char_t char_in;
  logic  end_of_token;

  modport source (output valid, char_in, end_of_token, input ready);
  modport sink   (input valid, char_in, end_of_token, output ready);
endinterface

interface iws_out_if;
  import iws_pkg::*;
  logic  valid;
  logic  ready;
  char_t char_out;
  logic  has_char;
  logic  token_done;

  modport source (output valid, char_out, has_char, token_done, input ready);
  modport sink   (input valid, char_out, has_char, token_done, output ready);
endinterface

/* design/identifier_word_splitter_core.sv */
// Identifier word splitter: top level.
// Path: an input beat lands in the input register, its result beats (up to four)
//   are formed in one pass and loaded into the result register once it is free.
// Throughput: one input beat per cycle while each beat yields at most one result and
//   the output is ready; otherwise bounded by the output side, one result beat per cycle.
// Reset: synchronous, active-low rst_n clears the token state and both valid flags.
module identifier_word_splitter_core (
  input  logic             clk,
  input  logic             rst_n,
  iws_in_if.sink           in_ch,
  iws_out_if.source        out_ch
);
  import iws_pkg::*;

  // Input register stage
  logic  stg_valid_r;
  char_t stg_char_r;
  logic  stg_eot_r;

  // Token state: the held byte waits for its lookahead byte
  char_t held_r, held_nxt;
  logic  held_valid_r, held_valid_nxt;
  char_t prev_r, prev_nxt;       // raw byte before the held one, 0 = none
  logic  started_r, started_nxt;
  logic  last_sp_r, last_sp_nxt;

  // Result register: one item's worth of result beats, drained by bnd_idx_r
  logic             bnd_valid_r;
  char_t [3:0]      bnd_char_r, bnd_char_nxt;
  logic  [1:0]      bnd_last_r, bnd_last_nxt;
  logic  [1:0]      bnd_idx_r;
  logic             bnd_eot_r, bnd_bare_r, bnd_bare_nxt;
  logic             bnd_load_nxt;

  logic stg_adv, bnd_free, bnd_done, last_beat;

  emit_t first_e, second_e;
  char_t second_prev;
  logic  [1:0] n1, n2;
  logic  [2:0] n_tot;
  char_t [1:0] fb, sb;
  logic  [1:0] iv, jv;

  // Per-byte rule: underscore collapses to a space, upper case may take a break.
  function automatic emit_t handle_byte(char_t cur, char_t prv, char_t nxt,
                                        logic has_next, logic st, logic ls);
    emit_t e;
    logic  brk;
    e.cnt     = 2'd0;
    e.b0      = SPACE_C;
    e.b1      = cur;
    e.started = st;
    e.last_sp = ls;
    brk = is_upper(cur) &&
          (is_lower(prv) || (has_next && is_upper(prv) && is_lower(nxt)));
    if (cur == UNDERSCORE_C) begin
      if (st && !ls) begin
        e.cnt     = 2'd1;
        e.last_sp = 1'b1;
      end
    end else begin
      if (st && brk) begin
        e.cnt = 2'd2;
      end else begin
        e.cnt = 2'd1;
        e.b0  = cur;
      end
      e.started = 1'b1;
      e.last_sp = (cur == SPACE_C);
    end
    return e;
  endfunction

  // Output side
  assign last_beat = (bnd_idx_r == bnd_last_r);
  assign bnd_done  = bnd_valid_r && out_ch.ready && last_beat;
  assign bnd_free  = !bnd_valid_r || bnd_done;
  assign stg_adv   = stg_valid_r && bnd_free;
  assign in_ch.ready = !stg_valid_r || stg_adv;

  assign out_ch.valid      = bnd_valid_r;
  assign out_ch.char_out   = bnd_bare_r ? '0 : bnd_char_r[bnd_idx_r];
  assign out_ch.has_char   = !bnd_bare_r;
  assign out_ch.token_done = bnd_eot_r && last_beat;

  // One pass: held byte (with the staged byte as lookahead), then the staged
  // byte itself if it closes the token.
  always_comb begin
    if (held_valid_r) begin
      first_e = handle_byte(held_r, prev_r, stg_char_r, 1'b1, started_r, last_sp_r);
    end else begin
      first_e = '{cnt: 2'd0, b0: SPACE_C, b1: SPACE_C,
                  started: started_r, last_sp: last_sp_r};
    end
    second_prev = held_valid_r ? held_r : prev_r;
    second_e = handle_byte(stg_char_r, second_prev, '0, 1'b0,
                           first_e.started, first_e.last_sp);

    n1 = first_e.cnt;
    n2 = stg_eot_r ? second_e.cnt : 2'd0;
    n_tot = {1'b0, n1} + {1'b0, n2};
    fb[0] = first_e.b0;
    fb[1] = first_e.b1;
    sb[0] = second_e.b0;
    sb[1] = second_e.b1;

    for (int i = 0; i < 4; i++) begin
      iv = 2'(i);
      jv = iv - n1;
      bnd_char_nxt[i] = (iv < n1) ? fb[iv[0]] : sb[jv[0]];
    end

    bnd_bare_nxt = stg_eot_r && (n_tot == 3'd0);
    bnd_last_nxt = bnd_bare_nxt ? 2'd0 : 2'(n_tot - 3'd1);
    bnd_load_nxt = (n_tot != 3'd0) || stg_eot_r;

    if (stg_eot_r) begin
      // token closes: back to the idle token state
      held_nxt       = '0;
      held_valid_nxt = 1'b0;
      prev_nxt       = '0;
      started_nxt    = 1'b0;
      last_sp_nxt    = 1'b0;
    end else begin
      held_nxt       = stg_char_r;
      held_valid_nxt = 1'b1;
      prev_nxt       = second_prev;
      started_nxt    = first_e.started;
      last_sp_nxt    = first_e.last_sp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r  <= 1'b0;
      held_valid_r <= 1'b0;
      held_r       <= '0;
      prev_r       <= '0;
      started_r    <= 1'b0;
      last_sp_r    <= 1'b0;
      bnd_valid_r  <= 1'b0;
      bnd_idx_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        stg_valid_r <= in_ch.valid;
      end

      if (stg_adv) begin
        held_r       <= held_nxt;
        held_valid_r <= held_valid_nxt;
        prev_r       <= prev_nxt;
        started_r    <= started_nxt;
        last_sp_r    <= last_sp_nxt;
      end

      if (bnd_free) begin
        bnd_valid_r <= stg_adv && bnd_load_nxt;
        bnd_idx_r   <= '0;
      end else if (bnd_valid_r && out_ch.ready) begin
        bnd_idx_r <= bnd_idx_r + 2'd1;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_char_r <= in_ch.char_in;
      stg_eot_r  <= in_ch.end_of_token;
    end
    if (stg_adv) begin
      bnd_char_r <= bnd_char_nxt;
      bnd_last_r <= bnd_last_nxt;
      bnd_eot_r  <= stg_eot_r;
      bnd_bare_r <= bnd_bare_nxt;
    end
  end

endmodule

/* bench/word_split_checker.sv */
// Scoreboard for the identifier word splitter: predicts result beats and checks them.
`timescale 1ns / 100ps
module word_split_checker (
  input  logic clk,
  input  logic rst_n,
  iws_in_if    in_mon,
  iws_out_if   out_mon,
  output int   err_cnt,
  output int   exp_left
);
  import iws_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  has_char;
    logic  done;
  } word_beat_t;

  word_beat_t split_q[$];   // beats still owed by the block, oldest first
  word_beat_t step_q[$];    // beats produced by one input beat

  // Token state
  char_t held_ch;
  char_t prev_ch;
  logic  held_vld;
  logic  started;
  logic  last_sp;

  function automatic logic lc_letter(char_t c);
    return (c >= LOWER_A_C) && (c <= LOWER_Z_C);
  endfunction

  function automatic logic uc_letter(char_t c);
    return (c >= UPPER_A_C) && (c <= UPPER_Z_C);
  endfunction

  task automatic clear_token();
    held_ch  = '0;
    prev_ch  = '0;
    held_vld = 1'b0;
    started  = 1'b0;
    last_sp  = 1'b0;
  endtask

  task automatic emit_ch(char_t c);
    step_q.insert(step_q.size(), '{ch: c, has_char: 1'b1, done: 1'b0});
    started = 1'b1;
    last_sp = (c == SPACE_C);
  endtask

  // One token byte with its raw predecessor and (if any) its successor.
  task automatic split_one(char_t cur, char_t prv, char_t nxt, logic has_nxt);
    logic brk;
    if (cur == UNDERSCORE_C) begin
      if (started && !last_sp) emit_ch(SPACE_C);
    end else begin
      brk = uc_letter(cur) &&
            (lc_letter(prv) || (has_nxt && uc_letter(prv) && lc_letter(nxt)));
      if (started && brk) emit_ch(SPACE_C);
      emit_ch(cur);
    end
  endtask

  task automatic predict_split(char_t c, logic eot);
    word_beat_t tail;
    step_q.delete();
    if (held_vld) begin
      split_one(held_ch, prev_ch, c, 1'b1);
      prev_ch = held_ch;
    end
    if (eot) begin
      split_one(c, prev_ch, '0, 1'b0);
      if (step_q.size() == 0) begin
        step_q.insert(0, '{ch: '0, has_char: 1'b0, done: 1'b1});
      end else begin
        tail      = step_q.pop_back();
        tail.done = 1'b1;
        step_q.insert(step_q.size(), tail);
      end
      clear_token();
    end else begin
      held_ch  = c;
      held_vld = 1'b1;
    end
    foreach (step_q[i]) split_q.insert(split_q.size(), step_q[i]);
  endtask

  initial begin
    err_cnt  = 0;
    exp_left = 0;
    clear_token();
  end

  // Output is checked before the input beat of the same edge is predicted,
  // so a beat can never be matched against its own cause.
  always @(posedge clk) begin : watch
    word_beat_t want;
    word_beat_t got;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{ch: out_mon.char_out, has_char: out_mon.has_char,
                done: out_mon.token_done};
        if (split_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat, expected none, got char=%02h has_char=%b done=%b",
                   $time, got.ch, got.has_char, got.done);
        end else begin
          want = split_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display({"%0t: beat mismatch, expected char=%02h has_char=%b done=%b,",
                      " got char=%02h has_char=%b done=%b"},
                     $time, want.ch, want.has_char, want.done,
                     got.ch, got.has_char, got.done);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_split(in_mon.char_in, in_mon.end_of_token);
    end
    exp_left = split_q.size();
  end

endmodule

/* bench/tb_top.sv */
// Top of the word splitter testbench: clock, reset, byte stimulus, result stalls, verdict.
`timescale 1ns / 100ps
module tb_top;
  import iws_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;  // watchdog, far above a slow clean run
  localparam int unsigned ITEM_TARGET    = 310;     // random part stops past this beat count
  localparam int unsigned SQUEEZE_CYCLES = 300;     // one long result-side hold-off
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam char_t       DIGIT_0_C      = 8'h30;
  localparam char_t       DIGIT_9_C      = 8'h39;

  typedef char_t token_t[$];

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  iws_in_if  in_ch ();
  iws_out_if out_ch ();

  int          err_cnt;
  int          exp_left;
  int unsigned sent_cnt  = 0;
  int unsigned calm_left = 0;   // beats left in a no-gap stretch
  logic        squeeze_req;     // stimulus asks the receiver for its long hold-off

  identifier_word_splitter_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_split_checker i_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .err_cnt  (err_cnt),
    .exp_left (exp_left)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sender idle length: mostly none or short, now and then long,
  // and occasionally a stretch of back-to-back beats.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // One input beat; returns at the edge where it is taken.
  // valid only gets one nonblocking write per edge: either dropped for a gap
  // or (re)asserted with the new payload.
  task automatic send_beat(char_t c, logic eot);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_in      <= c;
    in_ch.end_of_token <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_token(token_t tok);
    foreach (tok[i]) send_beat(tok[i], i == tok.size() - 1);
  endtask

  function automatic token_t str_token(string s);
    token_t q;
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), char_t'(s[i]));
    return q;
  endfunction

  // Identifier-like byte: letters of both cases, underscores, digits, a little noise.
  function automatic char_t ident_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return char_t'($urandom_range(LOWER_A_C, LOWER_Z_C));
    if (r < 65) return char_t'($urandom_range(UPPER_A_C, UPPER_Z_C));
    if (r < 80) return UNDERSCORE_C;
    if (r < 90) return char_t'($urandom_range(DIGIT_0_C, DIGIT_9_C));
    return char_t'($urandom_range(0, 255));
  endfunction

  function automatic token_t rand_token();
    token_t      q;
    int unsigned len;
    logic        noisy;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
    noisy = ($urandom_range(0, 6) == 0);
    repeat (len) begin
      if (noisy) q.insert(q.size(), char_t'($urandom_range(0, 255)));
      else       q.insert(q.size(), ident_char());
    end
    return q;
  endfunction

  // Result side: runs of ready and stall of random length. Once the stimulus
  // raises squeeze_req the receiver holds off for SQUEEZE_CYCLES so the block
  // backs up into its input.
  initial begin : rx_side
    int unsigned run_len;
    logic        squeezed;
    squeezed      = 1'b0;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed      = 1'b1;
        out_ch.ready <= 1'b0;
        run_len       = SQUEEZE_CYCLES;
      end else if ($urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        run_len       = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 6);
      end else begin
        out_ch.ready <= 1'b0;
        run_len       = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(1, 3);
      end
      repeat (run_len) @(posedge clk);
    end
  end

  // Hard stop if the block hangs or drops beats.
  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stim
    token_t tok;
    in_ch.valid        <= 1'b0;
    in_ch.char_in      <= '0;
    in_ch.end_of_token <= 1'b0;
    squeeze_req        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed tokens
    send_token(str_token("_"));       // nothing emitted: bare end marker
    send_token(str_token("a"));
    send_token(str_token("Z"));
    send_token(str_token("aB"));      // lower then upper
    send_token(str_token("ABc"));     // upper run ending before lower
    send_token(str_token("AB"));      // last byte has no lookahead
    send_token(str_token("x_"));      // trailing underscore closes token
    send_token(str_token("_x__Y"));   // leading and doubled underscores
    tok = '{LOWER_A_C, 8'h00, UPPER_A_C + 8'd1};   // zero byte as predecessor
    send_token(tok);
    tok = '{8'hFF, 8'h80, LOWER_Z_C};              // high bytes pass through
    send_token(tok);

    // Random tokens; the long result stall fires early in this part
    squeeze_req <= 1'b1;
    while (sent_cnt < ITEM_TARGET) send_token(rand_token());
    in_ch.valid <= 1'b0;

    // Let the checker see the final input beat, then drain.
    @(posedge clk);
    while (exp_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && exp_left == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
design/iws_pkg.sv
design/iws_if.sv
design/identifier_word_splitter_core.sv
bench/word_split_checker.sv
bench/tb_top.sv
